[rtl/crcfp_pkg.sv]
// ----------------------------------------------------------------------------
// crcfp_pkg
// Shared types, constants and the CRC-16/MODBUS byte update for the framed
// packet parser.
// ----------------------------------------------------------------------------
package crcfp_pkg;

	// Configuration register indexes.
	localparam logic REG_SYNC_FIRST  = 1'b0;
	localparam logic REG_SYNC_SECOND = 1'b1;

	localparam logic [7:0] SYNC_FIRST_RST  = 8'hAA;
	localparam logic [7:0] SYNC_SECOND_RST = 8'h55;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	// Frame descriptor queue and payload bank sizing. With three queued
	// frames at most, the fourth bank is always free for the frame being
	// received.
	localparam int Q_DEPTH = 3;
	localparam int Q_PTR_W = 2;
	localparam int BANK_W  = 2;

	typedef enum logic [2:0] {
		PH_SYNC1 = 3'd0,
		PH_SYNC2 = 3'd1,
		PH_LEN   = 3'd2,
		PH_CMD   = 3'd3,
		PH_DATA  = 3'd4,
		PH_CRCLO = 3'd5,
		PH_CRCHI = 3'd6
	} phase_t;

	typedef enum logic [1:0] {
		BK_IDLE = 2'd0,
		BK_READ = 2'd1,
		BK_LOAD = 2'd2
	} back_state_t;

	function automatic logic [15:0] crc16_update(input logic [15:0] crc_in,
	                                             input logic [7:0] b);
		logic [15:0] c;
		c = crc_in ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

[rtl/crcfp_ram.sv]
// ----------------------------------------------------------------------------
// crcfp_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module crcfp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128,
	localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AddrW-1:0] waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AddrW-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[rtl/crcfp_front.sv]
// ----------------------------------------------------------------------------
// crcfp_front
// Byte parser: sync hunt, length and command capture, payload write into the
// current bank, running CRC and frame check. Good frames are pushed to the
// descriptor queue.
// ----------------------------------------------------------------------------
module crcfp_front #(
	parameter int MAX_PAYLOAD = 32,
	localparam int LenW = $clog2(MAX_PAYLOAD + 1),
	localparam int PosW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic                             cfg_index,
	input  logic [7:0]                       cfg_data,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [7:0]                       rx_byte,
	input  logic                             q_full,
	output logic                             q_push,
	output logic [7:0]                       q_cmd,
	output logic [LenW-1:0]                  q_len,
	output logic                             ram_we,
	output logic [crcfp_pkg::BANK_W+PosW-1:0] ram_waddr,
	output logic [7:0]                       ram_wdata
);

	crcfp_pkg::phase_t phase_q, phase_d;
	logic [7:0]            sync1_q, sync2_q;
	logic [LenW-1:0]       len_q;
	logic [7:0]            cmd_q;
	logic [LenW-1:0]       count_q;
	logic [LenW-1:0]       count_inc;
	logic [7:0]            crc_lo_q;
	logic [15:0]           crc_q;
	logic [15:0]           crc_src;
	logic [15:0]           crc_next;
	logic [crcfp_pkg::BANK_W-1:0] bank_q;
	logic                  accept;
	logic                  crc_ok;
	logic                  len_bad;

	assign accept    = in_valid && !in_stall;
	assign count_inc = count_q + 1'b1;
	assign crc_src   = (phase_q == crcfp_pkg::PH_LEN) ? crcfp_pkg::CRC_INIT : crc_q;
	assign crc_next  = crcfp_pkg::crc16_update(crc_src, rx_byte);
	assign crc_ok    = (crc_lo_q == crc_q[7:0]) && (rx_byte == crc_q[15:8]);
	assign len_bad   = rx_byte > 8'(MAX_PAYLOAD);

	// Next phase.
	always_comb begin
		phase_d = phase_q;
		if (accept) begin
			case (phase_q)
				crcfp_pkg::PH_SYNC1: begin
					if (rx_byte == sync1_q) begin
						phase_d = crcfp_pkg::PH_SYNC2;
					end
				end
				crcfp_pkg::PH_SYNC2: begin
					phase_d = (rx_byte == sync2_q) ? crcfp_pkg::PH_LEN
					                              : crcfp_pkg::PH_SYNC1;
				end
				crcfp_pkg::PH_LEN: begin
					phase_d = len_bad ? crcfp_pkg::PH_SYNC1 : crcfp_pkg::PH_CMD;
				end
				crcfp_pkg::PH_CMD: begin
					phase_d = (len_q == '0) ? crcfp_pkg::PH_CRCLO : crcfp_pkg::PH_DATA;
				end
				crcfp_pkg::PH_DATA: begin
					if (count_inc >= len_q) begin
						phase_d = crcfp_pkg::PH_CRCLO;
					end
				end
				crcfp_pkg::PH_CRCLO: begin
					phase_d = crcfp_pkg::PH_CRCHI;
				end
				default: begin
					phase_d = crcfp_pkg::PH_SYNC1;
				end
			endcase
		end
	end

	// Outputs. The closing CRC byte waits while the queue is full.
	always_comb begin
		in_stall  = (phase_q == crcfp_pkg::PH_CRCHI) && q_full;
		ram_we    = accept && (phase_q == crcfp_pkg::PH_DATA);
		ram_waddr = {bank_q, count_q[PosW-1:0]};
		ram_wdata = rx_byte;
		q_push    = accept && (phase_q == crcfp_pkg::PH_CRCHI) && crc_ok;
		q_cmd     = cmd_q;
		q_len     = len_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync1_q <= crcfp_pkg::SYNC_FIRST_RST;
			sync2_q <= crcfp_pkg::SYNC_SECOND_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				crcfp_pkg::REG_SYNC_FIRST:  sync1_q <= cfg_data;
				crcfp_pkg::REG_SYNC_SECOND: sync2_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= crcfp_pkg::PH_SYNC1;
			len_q    <= '0;
			cmd_q    <= '0;
			count_q  <= '0;
			crc_lo_q <= '0;
			crc_q    <= crcfp_pkg::CRC_INIT;
			bank_q   <= '0;
		end else if (accept) begin
			phase_q <= phase_d;
			case (phase_q)
				crcfp_pkg::PH_LEN: begin
					if (!len_bad) begin
						len_q   <= LenW'(rx_byte);
						count_q <= '0;
						crc_q   <= crc_next;
					end
				end
				crcfp_pkg::PH_CMD: begin
					cmd_q <= rx_byte;
					crc_q <= crc_next;
				end
				crcfp_pkg::PH_DATA: begin
					crc_q   <= crc_next;
					count_q <= count_inc;
				end
				crcfp_pkg::PH_CRCLO: begin
					crc_lo_q <= rx_byte;
				end
				crcfp_pkg::PH_CRCHI: begin
					// A good frame keeps its bank; the next frame uses the following one.
					if (crc_ok) begin
						bank_q <= bank_q + 1'b1;
					end
					len_q    <= '0;
					cmd_q    <= '0;
					count_q  <= '0;
					crc_lo_q <= '0;
					crc_q    <= crcfp_pkg::CRC_INIT;
				end
				crcfp_pkg::PH_SYNC1, crcfp_pkg::PH_SYNC2: ;
				default: begin
					len_q    <= '0;
					cmd_q    <= '0;
					count_q  <= '0;
					crc_lo_q <= '0;
					crc_q    <= crcfp_pkg::CRC_INIT;
				end
			endcase
		end
	end

endmodule

[rtl/crcfp_queue.sv]
// ----------------------------------------------------------------------------
// crcfp_queue
// Short descriptor queue between the parser and the read-out engine.
// ----------------------------------------------------------------------------
module crcfp_queue #(
	parameter int WIDTH = 14
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic [WIDTH-1:0] head_data,
	output logic             empty,
	output logic             full
);

	logic [WIDTH-1:0]                 entry_q [crcfp_pkg::Q_DEPTH];
	logic [crcfp_pkg::Q_PTR_W-1:0]    wr_ptr_q, rd_ptr_q;
	logic [crcfp_pkg::Q_PTR_W-1:0]    count_q;

	function automatic logic [crcfp_pkg::Q_PTR_W-1:0] ptr_next(
		input logic [crcfp_pkg::Q_PTR_W-1:0] p);
		return (p == crcfp_pkg::Q_PTR_W'(crcfp_pkg::Q_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign empty     = (count_q == '0);
	assign full      = (count_q == crcfp_pkg::Q_PTR_W'(crcfp_pkg::Q_DEPTH));
	assign head_data = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[rtl/crcfp_back.sv]
// ----------------------------------------------------------------------------
// crcfp_back
// Read-out engine: takes the frame at the head of the queue and emits one
// result per payload byte from its bank, or one result for an empty frame.
// ----------------------------------------------------------------------------
module crcfp_back #(
	parameter int MAX_PAYLOAD = 32,
	localparam int LenW = $clog2(MAX_PAYLOAD + 1),
	localparam int PosW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              q_empty,
	input  logic [7:0]                        q_cmd,
	input  logic [LenW-1:0]                   q_len,
	output logic                              q_pop,
	output logic                              ram_re,
	output logic [crcfp_pkg::BANK_W+PosW-1:0] ram_raddr,
	input  logic [7:0]                        ram_rdata,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [7:0]                        frame_cmd,
	output logic [5:0]                        frame_len,
	output logic [7:0]                        data_byte,
	output logic [4:0]                        data_pos,
	output logic                              is_last
);

	crcfp_pkg::back_state_t state_q, state_d;
	logic [PosW-1:0]              pos_q;
	logic [crcfp_pkg::BANK_W-1:0] bank_q;
	logic                         out_valid_q;
	logic [7:0]                   cmd_q;
	logic [5:0]                   len_out_q;
	logic [7:0]                   byte_q;
	logic [4:0]                   pos_out_q;
	logic                         last_q;
	logic                         slot_free;
	logic                         load;
	logic                         last_now;

	assign slot_free = !out_valid_q || !out_stall;
	assign last_now  = (q_len == '0) || ((LenW'(pos_q) + 1'b1) == q_len);

	always_comb begin
		state_d = state_q;
		case (state_q)
			crcfp_pkg::BK_IDLE: begin
				if (!q_empty) begin
					state_d = (q_len == '0) ? crcfp_pkg::BK_LOAD : crcfp_pkg::BK_READ;
				end
			end
			crcfp_pkg::BK_READ: begin
				state_d = crcfp_pkg::BK_LOAD;
			end
			crcfp_pkg::BK_LOAD: begin
				if (slot_free) begin
					state_d = last_now ? crcfp_pkg::BK_IDLE : crcfp_pkg::BK_READ;
				end
			end
			default: begin
				state_d = crcfp_pkg::BK_IDLE;
			end
		endcase
	end

	always_comb begin
		ram_re    = (state_q == crcfp_pkg::BK_READ);
		ram_raddr = {bank_q, pos_q};
		load      = (state_q == crcfp_pkg::BK_LOAD) && slot_free;
		q_pop     = load && last_now;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= crcfp_pkg::BK_IDLE;
			pos_q       <= '0;
			bank_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (q_pop) begin
				pos_q  <= '0;
				bank_q <= bank_q + 1'b1;
			end else if (load) begin
				pos_q <= pos_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			cmd_q     <= q_cmd;
			len_out_q <= 6'(q_len);
			byte_q    <= (q_len == '0) ? 8'h00 : ram_rdata;
			pos_out_q <= 5'(pos_q);
			last_q    <= last_now;
		end
	end

	assign out_valid = out_valid_q;
	assign frame_cmd = cmd_q;
	assign frame_len = len_out_q;
	assign data_byte = byte_q;
	assign data_pos  = pos_out_q;
	assign is_last   = last_q;

endmodule

[rtl/crc16_framed_packet_parser.sv]
// With the read-out engine idle, a good frame's first result follows its closing CRC byte
// via the queue, the RAM read and the output register; an empty frame skips the RAM read.
// Throughput: one received byte per cycle; the closing CRC byte waits only while three
// checked frames fill the queue. Each payload byte is read from the registered RAM before its result is loaded.
// Reset (asynchronous, active low) returns the parser to the sync hunt with the
// default sync bytes and empties the queue; the payload RAM is not cleared.
// ----------------------------------------------------------------------------
// crc16_framed_packet_parser
// Sync-framed byte stream parser with CRC-16/MODBUS check and payload
// read-out, split into a parser front, a descriptor queue and a read-out back.
// ----------------------------------------------------------------------------
module crc16_framed_packet_parser #(
	parameter int MAX_PAYLOAD = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic [7:0] cfg_data,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] frame_cmd,
	output logic [5:0] frame_len,
	output logic [7:0] data_byte,
	output logic [4:0] data_pos,
	output logic       is_last
);

	localparam int LenW  = $clog2(MAX_PAYLOAD + 1);
	localparam int PosW  = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
	localparam int AddrW = crcfp_pkg::BANK_W + PosW;
	localparam int DescW = 8 + LenW;

	logic             q_push, q_pop, q_empty, q_full;
	logic [7:0]       push_cmd;
	logic [LenW-1:0]  push_len;
	logic [DescW-1:0] head_desc;
	logic             ram_we, ram_re;
	logic [AddrW-1:0] ram_waddr, ram_raddr;
	logic [7:0]       ram_wdata, ram_rdata;

	crcfp_front #(
		.MAX_PAYLOAD(MAX_PAYLOAD)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.rx_byte   (rx_byte),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_cmd     (push_cmd),
		.q_len     (push_len),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata)
	);

	crcfp_queue #(
		.WIDTH(DescW)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data ({push_cmd, push_len}),
		.pop       (q_pop),
		.head_data (head_desc),
		.empty     (q_empty),
		.full      (q_full)
	);

	crcfp_ram #(
		.WIDTH(8),
		.DEPTH((1 << crcfp_pkg::BANK_W) << PosW)
	) u_payload_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	crcfp_back #(
		.MAX_PAYLOAD(MAX_PAYLOAD)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_cmd     (head_desc[DescW-1:LenW]),
		.q_len     (head_desc[LenW-1:0]),
		.q_pop     (q_pop),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.frame_cmd (frame_cmd),
		.frame_len (frame_len),
		.data_byte (data_byte),
		.data_pos  (data_pos),
		.is_last   (is_last)
	);

endmodule
